@@ rtl/core/bmpq_pkg.sv @@
package bmpq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PRIO_W = 16;
    localparam int TAG_W = 16;
    localparam int LIMIT_W = 5;
    localparam int STAT_W = 2;
    localparam int FIFO_DEPTH = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
    localparam int ADDR_W = 1;
    localparam logic [ADDR_W-1:0] REG_QUEUE_LIMIT = 1'b0;

    // classified operation handed from front to back
    typedef struct packed {
        logic              extract;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  occupancy;
    } res_t;

endpackage

@@ rtl/core/bmpq_front.sv @@
module bmpq_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bmpq_pkg::op_t in_op,
    output logic          op_valid,
    input  logic          op_ready,
    output bmpq_pkg::op_t op_out
);
    import bmpq_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    op_t                fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     fill_reg;
    logic               push, pop;

    assign in_ready = (fill_reg != (PTR_W+1)'(FIFO_DEPTH));
    assign op_valid = (fill_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = op_valid && op_ready;
    assign op_out = fifo_reg[rd_ptr_reg];

    // short queue between front and back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
        end
    end

    // classify: an extract drops its fields
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg].extract <= in_op.extract;
            fifo_reg[wr_ptr_reg].prio <= in_op.extract ? '0 : in_op.prio;
            fifo_reg[wr_ptr_reg].tag <= in_op.extract ? '0 : in_op.tag;
        end
    end

endmodule

@@ rtl/core/bmpq_back.sv @@
module bmpq_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bmpq_pkg::LIMIT_W-1:0]  queue_limit,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  bmpq_pkg::op_t                 op_in,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bmpq_pkg::res_t                res_out,
    output logic [bmpq_pkg::CNT_W-1:0]    count
);
    import bmpq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;

    logic [PRIO_W-1:0]  prio_reg [DEPTH];
    logic [TAG_W-1:0]   tag_reg [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         state_reg;
    logic [IDX_W-1:0]   best_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    res_t               res_reg;

    // min tree nodes, heap order, leaves at DEPTH and up
    logic [PRIO_W-1:0]  node_prio [2*DEPTH];
    logic [IDX_W-1:0]   node_idx [2*DEPTH];
    logic               node_ok [2*DEPTH];
    logic [IDX_W-1:0]   min_idx;
    logic [CNT_W-1:0]   lim_eff;
    logic               can_take;

    assign count = count_reg;
    assign res_valid = res_valid_reg;
    assign res_out = res_reg;
    assign can_take = !res_valid_reg || res_ready;
    assign op_ready = (state_reg == ST_IDLE) && can_take;
    assign lim_eff = (queue_limit > LIMIT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(queue_limit);

    // oldest minimum over valid slots, lower index wins ties
    always_comb begin
        node_prio[0] = '0;
        node_idx[0] = '0;
        node_ok[0] = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            node_prio[DEPTH+i] = prio_reg[i];
            node_idx[DEPTH+i] = IDX_W'(i);
            node_ok[DEPTH+i] = (CNT_W'(i) < count_reg);
        end
        for (int n = DEPTH - 1; n >= 1; n--) begin
            if (node_ok[2*n+1] && node_prio[2*n+1] < node_prio[2*n]) begin
                node_prio[n] = node_prio[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end else begin
                node_prio[n] = node_prio[2*n];
                node_idx[n] = node_idx[2*n];
            end
            node_ok[n] = node_ok[2*n];
        end
        min_idx = node_idx[1];
    end

    // result valid: loaded by every op except an extract heading to the search, whose result the find state loads
    always_comb begin
        res_valid_next = res_valid_reg && !res_ready;
        if (state_reg == ST_FIND) begin
            res_valid_next = 1'b1;
        end else if (state_reg == ST_IDLE && op_valid && can_take
                     && !(op_in.extract && count_reg != '0)) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (op_valid && can_take) begin
                        if (op_in.extract && count_reg != '0) begin
                            best_reg <= min_idx;
                            state_reg <= ST_FIND;
                        end else if (op_in.extract) begin
                            res_reg <= '{STAT_EMPTY, '0, '0, count_reg};
                        end else if (count_reg >= lim_eff) begin
                            res_reg <= '{STAT_FULL, '0, '0, count_reg};
                        end else begin
                            prio_reg[count_reg[IDX_W-1:0]] <= op_in.prio;
                            tag_reg[count_reg[IDX_W-1:0]] <= op_in.tag;
                            count_reg <= count_reg + 1'b1;
                            res_reg <= '{STAT_DONE, '0, '0, count_reg + 1'b1};
                        end
                    end
                end
                ST_FIND: begin
                    // remove chosen slot, close the gap
                    res_reg <= '{STAT_DONE, prio_reg[best_reg], tag_reg[best_reg],
                                 count_reg - 1'b1};
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (IDX_W'(i) >= best_reg) begin
                            prio_reg[i] <= prio_reg[i+1];
                            tag_reg[i] <= tag_reg[i+1];
                        end
                    end
                    count_reg <= count_reg - 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/bounded_min_priority_queue_top.sv @@
// channel   | ports                                         | direction
// input     | s_valid s_ready s_func s_priority_req s_payload | in
// result    | m_valid m_ready m_status m_out_priority m_out_payload m_occupancy | out
// config    | psel penable pwrite paddr pwdata prdata pready  | apb
// insert and rejected ops finish in the back end's idle state; extract also passes through
// the find state (the sixteen-way minimum search in idle, the shift-down in find)
// a two-item queue lets the front accept while the back works
// aresetn is synchronous; reset empties the queue and sets the limit to 16
// a stalled result holds the back end; the front fills until its queue is full
module bounded_min_priority_queue_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [bmpq_pkg::PRIO_W-1:0]     s_priority_req,
    input  logic [bmpq_pkg::TAG_W-1:0]      s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bmpq_pkg::STAT_W-1:0]     m_status,
    output logic [bmpq_pkg::PRIO_W-1:0]     m_out_priority,
    output logic [bmpq_pkg::TAG_W-1:0]      m_out_payload,
    output logic [bmpq_pkg::CNT_W-1:0]      m_occupancy,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmpq_pkg::ADDR_W+1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bmpq_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    op_t                in_op, mid_op;
    logic               mid_valid, mid_ready;
    res_t               res;
    logic [CNT_W-1:0]   count;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite
                     && paddr[ADDR_W+1:2] == REG_QUEUE_LIMIT) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end
    assign prdata = (paddr[ADDR_W+1:2] == REG_QUEUE_LIMIT)
                    ? {{(32-LIMIT_W){1'b0}}, limit_reg} : '0;

    assign in_op = '{s_func == FUNC_EXTRACT, s_priority_req, s_payload};

    bmpq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_op(in_op),
        .op_valid(mid_valid), .op_ready(mid_ready), .op_out(mid_op)
    );

    bmpq_back u_back (
        .aclk(aclk), .aresetn(aresetn), .queue_limit(limit_reg),
        .op_valid(mid_valid), .op_ready(mid_ready), .op_in(mid_op),
        .res_valid(m_valid), .res_ready(m_ready), .res_out(res), .count(count)
    );

    assign m_status = res.status;
    assign m_out_priority = res.prio;
    assign m_out_payload = res.tag;
    assign m_occupancy = res.occupancy;

    // occupancy never exceeds depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CNT_W'(DEPTH)) else $error("count above depth");
    // a reported full insert leaves the count unchanged at or above limit
    a_full_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_occupancy == count)
        else $error("full status with wrong occupancy");
    // empty status only reports zero occupancy
    a_empty_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_EMPTY |-> m_occupancy == '0)
        else $error("empty status with entries held");

endmodule
